>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define QRS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QRS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define QRS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/qrs_pkg.sv
package qrs_pkg;

   localparam int COEF_W = 32;
   localparam int CODE_W = 3;

   typedef enum logic [CODE_W-1:0] {
      CASE_TWO_REAL = 3'd0,
      CASE_COMPLEX  = 3'd1,
      CASE_DOUBLE   = 3'd2,
      CASE_LINEAR   = 3'd3,
      CASE_NONE     = 3'd4,
      CASE_ALL      = 3'd5
   } case_type;

   typedef struct packed {
      logic              ovf;
      logic [COEF_W-1:0] val;
   } sat_type;

endpackage

>>> rtl/core/qrs_if.sv
interface qrs_req_if import qrs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coef_quad;
   logic signed [COEF_W-1:0] coef_lin;
   logic signed [COEF_W-1:0] coef_const;

   modport source (output valid, coef_quad, coef_lin, coef_const, input ready);
   modport sink   (input valid, coef_quad, coef_lin, coef_const, output ready);
endinterface

interface qrs_rsp_if import qrs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CODE_W-1:0]        case_code;
   logic signed [COEF_W-1:0] root_one;
   logic signed [COEF_W-1:0] root_two;
   logic                     overflow;

   modport source (output valid, case_code, root_one, root_two, overflow, input ready);
   modport sink   (input valid, case_code, root_one, root_two, overflow, output ready);
endinterface

>>> rtl/core/qrs_div.sv
module qrs_div #(
   parameter int NW = 49,
   parameter int DW = 33
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo
);

   logic [NW-1:0] nq_ff  [0:NW-1];
   logic [DW-1:0] rem_ff [0:NW-1];
   logic [DW-1:0] den_ff [0:NW-1];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [NW-1:0] nq_cur;
      logic [DW-1:0] rem_cur;
      logic [DW-1:0] den_cur;
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;

      if (k == 0) begin : g_first
         assign nq_cur  = num;
         assign rem_cur = '0;
         assign den_cur = den;
      end else begin : g_next
         assign nq_cur  = nq_ff[k-1];
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
      end

      always_comb begin
         trial  = {rem_cur, nq_cur[NW-1]};
         ge     = trial >= {1'b0, den_cur};
         rem_in = ge ? DW'(trial - {1'b0, den_cur}) : trial[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[k]  <= {nq_cur[NW-2:0], ge};
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_cur;
         end
      end
   end

   assign quo = nq_ff[NW-1];

endmodule

>>> rtl/core/qrs_sqrt.sv
module qrs_sqrt #(
   parameter int QW = 49
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*QW-1:0] rad,
   output logic [QW-1:0]   root
);

   logic [2*QW-1:0] rad_ff  [0:QW-1];
   logic [QW:0]     rem_ff  [0:QW-1];
   logic [QW-1:0]   root_ff [0:QW-1];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [2*QW-1:0] rad_cur;
      logic [QW:0]     rem_cur;
      logic [QW-1:0]   root_cur;
      logic [QW+2:0]   trial;
      logic [QW+2:0]   test;
      logic            ge;

      if (k == 0) begin : g_first
         assign rad_cur  = rad;
         assign rem_cur  = '0;
         assign root_cur = '0;
      end else begin : g_next
         assign rad_cur  = rad_ff[k-1];
         assign rem_cur  = rem_ff[k-1];
         assign root_cur = root_ff[k-1];
      end

      always_comb begin
         trial = {rem_cur, rad_cur[2*QW-1 -: 2]};
         test  = {1'b0, root_cur, 2'b01};
         ge    = trial >= test;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= {rad_cur[2*QW-3:0], 2'b00};
            rem_ff[k]  <= ge ? (QW+1)'(trial - test) : trial[QW:0];
            root_ff[k] <= {root_cur[QW-2:0], ge};
         end
      end
   end

   assign root = root_ff[QW-1];

endmodule

>>> rtl/core/quadratic_root_solver.sv
// Channel   Modport       Payload
// req_ch    sink          coef_quad, coef_lin, coef_const (signed fixed point)
// rsp_ch    source        case_code, root_one, root_two, overflow
//
// One request enters per cycle while the response is not stalled.
// The pipeline depth is set by the square root followed by the spread divider, one
// result bit per stage; the vertex divider runs beside the square root.
// Reset is synchronous and clears only the valid bits.
// A stalled response freezes the whole pipeline, and req_ch.ready falls with it.
`include "assert_macros.svh"

module quadratic_root_solver import qrs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   qrs_req_if.sink   req_ch,
   qrs_rsp_if.source rsp_ch
);

   localparam int QW = 33 + FRAC_BITS;
   localparam int DW = 33;
   localparam int SW = QW + 2;

   typedef struct packed {
      case_type      code;
      logic          neg;
      logic [DW-1:0] den;
   } meta1_type;

   typedef struct packed {
      case_type      code;
      logic          neg;
      logic [QW-1:0] quo;
   } meta2_type;

   logic adv;
   logic [0:2*QW+1] vld_ff;
   logic            out_vld_ff;

   // First stage: magnitudes and products.
   logic [31:0] ma_in, mb_in, mc_in;
   logic [31:0] ma_ff, mb_ff, mc_ff;
   logic [63:0] b2_ff, pac_ff;
   logic        a_nz_ff, b_nz_ff, c_nz_ff, same_ac_ff, neg_ff;

   always_comb begin
      ma_in = req_ch.coef_quad[31]  ? 32'(-req_ch.coef_quad)  : req_ch.coef_quad;
      mb_in = req_ch.coef_lin[31]   ? 32'(-req_ch.coef_lin)   : req_ch.coef_lin;
      mc_in = req_ch.coef_const[31] ? 32'(-req_ch.coef_const) : req_ch.coef_const;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ma_ff      <= ma_in;
         mb_ff      <= mb_in;
         mc_ff      <= mc_in;
         b2_ff      <= mb_in * mb_in;
         pac_ff     <= ma_in * mc_in;
         a_nz_ff    <= req_ch.coef_quad != '0;
         b_nz_ff    <= req_ch.coef_lin != '0;
         c_nz_ff    <= req_ch.coef_const != '0;
         same_ac_ff <= req_ch.coef_quad[31] == req_ch.coef_const[31];
         if (req_ch.coef_quad != '0) begin
            neg_ff <= req_ch.coef_lin[31] == req_ch.coef_quad[31];
         end else begin
            neg_ff <= req_ch.coef_const[31] == req_ch.coef_lin[31];
         end
      end
   end

   // Second stage: discriminant, case selection and divider operands.
   logic [65:0]     p4, b2x, mag_in;
   case_type        code_in;
   logic [2*QW-1:0] rad_ff;
   logic [QW-1:0]   n1_ff;
   logic [DW-1:0]   d1_ff, d2_ff;
   case_type        code_ff;
   logic            neg2_ff;

   always_comb begin
      p4      = {pac_ff, 2'b00};
      b2x     = {2'b00, b2_ff};
      mag_in  = b2x + p4;
      code_in = CASE_TWO_REAL;
      if (a_nz_ff) begin
         if (c_nz_ff && same_ac_ff) begin
            if (b2x > p4) begin
               mag_in = b2x - p4;
            end else if (b2x < p4) begin
               mag_in  = p4 - b2x;
               code_in = CASE_COMPLEX;
            end else begin
               mag_in  = b2x;
               code_in = CASE_DOUBLE;
            end
         end else if (mag_in == '0) begin
            code_in = CASE_DOUBLE;
         end
      end else if (b_nz_ff) begin
         code_in = CASE_LINEAR;
      end else if (c_nz_ff) begin
         code_in = CASE_NONE;
      end else begin
         code_in = CASE_ALL;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= {mag_in, {(2*FRAC_BITS){1'b0}}};
         n1_ff   <= QW'({(a_nz_ff ? mb_ff : mc_ff), {FRAC_BITS{1'b0}}});
         d1_ff   <= a_nz_ff ? {ma_ff, 1'b0} : {1'b0, mb_ff};
         d2_ff   <= {ma_ff, 1'b0};
         code_ff <= code_in;
         neg2_ff <= neg_ff;
      end
   end

   // Square root and the vertex (or linear) quotient run side by side.
   logic [QW-1:0] root, q1, q2;
   meta1_type     m1_ff [0:QW-1];
   meta2_type     m2_ff [0:QW-1];

   qrs_sqrt #(.QW(QW)) u_sqrt (
      .clock (clock),
      .en    (adv),
      .rad   (rad_ff),
      .root  (root)
   );

   qrs_div #(.NW(QW), .DW(DW)) u_div_vertex (
      .clock (clock),
      .en    (adv),
      .num   (n1_ff),
      .den   (d1_ff),
      .quo   (q1)
   );

   qrs_div #(.NW(QW), .DW(DW)) u_div_spread (
      .clock (clock),
      .en    (adv),
      .num   (root),
      .den   (m1_ff[QW-1].den),
      .quo   (q2)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff[0] <= '{code: code_ff, neg: neg2_ff, den: d2_ff};
         m2_ff[0] <= '{code: m1_ff[QW-1].code, neg: m1_ff[QW-1].neg, quo: q1};
         for (int k = 1; k < QW; k++) begin
            m1_ff[k] <= m1_ff[k-1];
            m2_ff[k] <= m2_ff[k-1];
         end
      end
   end

   // Output stage: combine, saturate and register.
   function automatic sat_type sat32(input logic signed [SW-1:0] v);
      sat_type r;
      if (v > SW'(signed'(32'h7fffffff))) begin
         r = '{ovf: 1'b1, val: 32'h7fffffff};
      end else if (v < SW'(signed'(32'h80000000))) begin
         r = '{ovf: 1'b1, val: 32'h80000000};
      end else begin
         r = '{ovf: 1'b0, val: v[31:0]};
      end
      return r;
   endfunction

   logic signed [SW-1:0] re, sq;
   sat_type              s1, s2;
   logic [CODE_W-1:0]    code_out_ff;
   logic [31:0]          r1_ff, r2_ff;
   logic                 ovf_ff;

   always_comb begin
      re = m2_ff[QW-1].neg ? -$signed({2'b00, m2_ff[QW-1].quo})
                           :  $signed({2'b00, m2_ff[QW-1].quo});
      sq = $signed({2'b00, q2});
      s1 = '0;
      s2 = '0;
      case (m2_ff[QW-1].code)
         CASE_TWO_REAL: begin
            s1 = sat32(re + sq);
            s2 = sat32(re - sq);
         end
         CASE_COMPLEX: begin
            s1 = sat32(re);
            s2 = sat32(sq);
         end
         CASE_DOUBLE: begin
            s1 = sat32(re);
            s2 = s1;
         end
         CASE_LINEAR: begin
            s1 = sat32(re);
         end
         default: begin
            s1 = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {req_ch.valid, vld_ff[0:2*QW]};
         out_vld_ff <= vld_ff[2*QW+1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         code_out_ff <= m2_ff[QW-1].code;
         r1_ff       <= s1.val;
         r2_ff       <= s2.val;
         ovf_ff      <= s1.ovf | s2.ovf;
      end
   end

   assign adv              = !out_vld_ff || rsp_ch.ready;
   assign req_ch.ready     = adv;
   assign rsp_ch.valid     = out_vld_ff;
   assign rsp_ch.case_code = code_out_ff;
   assign rsp_ch.root_one  = r1_ff;
   assign rsp_ch.root_two  = r2_ff;
   assign rsp_ch.overflow  = ovf_ff;

   `QRS_ASSERT_NXT(a_enter, clock, reset, req_ch.valid && req_ch.ready, vld_ff[0], "request lost at entry")
   `QRS_ASSERT_IMP(a_double, clock, reset, out_vld_ff && code_out_ff == CASE_DOUBLE, r1_ff == r2_ff, "double root differs")
   `QRS_ASSERT_IMP(a_order, clock, reset, out_vld_ff && code_out_ff == CASE_TWO_REAL, $signed(r1_ff) >= $signed(r2_ff), "real roots out of order")
   `QRS_ASSERT_IMP(a_empty, clock, reset, out_vld_ff && (code_out_ff == CASE_NONE || code_out_ff == CASE_ALL), r1_ff == '0 && r2_ff == '0 && !ovf_ff, "degenerate case carries values")

endmodule
